### src/mbps_pkg.sv
package mbps_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN = 2'd0,
      CSR_CARE    = 2'd1,
      CSR_LENGTH  = 2'd2,
      CSR_FIRST   = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_BITS = 64;

   typedef struct packed {
      logic [63:0] pattern_word;
      logic [7:0]  care_mask;
      logic [3:0]  pattern_length;
      logic        first_only;
   } cfg_type;

   // one classified item waiting for the output side
   typedef struct packed {
      logic        match_found;
      logic [31:0] match_offset;
      logic        end_of_region;
   } result_type;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   localparam int RSP_DATA_BITS = 40;

endpackage

### src/mbps_front.sv
module mbps_front #(
   parameter int PATTERN_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbps_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 push_ready,
   output logic                 push_valid,
   output mbps_pkg::result_type push_data
);

   localparam logic [3:0] LEN_MAX = 4'(PATTERN_BYTES);

   logic [7:0]  window_ff [PATTERN_BYTES];
   logic [7:0]  window_in [PATTERN_BYTES];
   logic [7:0]  shifted   [PATTERN_BYTES];
   logic [31:0] seen_ff, seen_in;
   logic        found_ff, found_in;

   logic [PATTERN_BYTES:1] len_hit;
   logic        window_hit;
   logic [3:0]  len_eff;
   logic [31:0] len_less;
   logic        seen_full;
   logic        accept;
   logic        found;
   logic [31:0] offset;

   assign accept   = in_valid && push_ready;
   assign in_ready = push_ready;

   // window after taking the new byte, newest at index 0
   always_comb begin
      shifted[0] = in_byte;
      for (int j = 1; j < PATTERN_BYTES; j++) begin
         shifted[j] = window_ff[j-1];
      end
   end

   // masked compare for every possible length
   always_comb begin
      for (int l = 1; l <= PATTERN_BYTES; l++) begin
         len_hit[l] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (cfg.care_mask[k] && (shifted[l-1-k] != cfg.pattern_word[8*k +: 8])) begin
               len_hit[l] = 1'b0;
            end
         end
      end
   end

   assign len_eff = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;

   always_comb begin
      window_hit = 1'b0;
      for (int l = 1; l <= PATTERN_BYTES; l++) begin
         if (len_eff == 4'(l)) begin
            window_hit = len_hit[l];
         end
      end
   end

   assign len_less  = {28'd0, len_eff - 4'd1};
   assign seen_full = (seen_ff == 32'hffff_ffff);

   assign found = !seen_full && (len_eff != 4'd0) && (seen_ff >= len_less)
                  && !(cfg.first_only && found_ff) && window_hit;
   assign offset = found ? (seen_ff - len_less) : 32'd0;

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      found_in  = found_ff;
      if (accept) begin
         if (in_last) begin
            for (int j = 0; j < PATTERN_BYTES; j++) begin
               window_in[j] = 8'd0;
            end
            seen_in  = 32'd0;
            found_in = 1'b0;
         end else begin
            window_in = shifted;
            seen_in   = seen_full ? seen_ff : seen_ff + 32'd1;
            found_in  = found_ff || found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PATTERN_BYTES; j++) begin
            window_ff[j] <= 8'd0;
         end
         seen_ff  <= 32'd0;
         found_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
         found_ff  <= found_in;
      end
   end

   assign push_valid              = accept && (found || in_last);
   assign push_data.match_found   = found;
   assign push_data.match_offset  = offset;
   assign push_data.end_of_region = in_last;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> (seen_ff == 32'd0) && !found_ff)
      else $error("region state not cleared after final byte");

   a_first_only_once: assert property (@(posedge clock) disable iff (reset)
      cfg.first_only && found_ff |-> !found)
      else $error("second match reported in first-only mode");

endmodule

### src/mbps_queue.sv
module mbps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  mbps_pkg::result_type push_data,
   output logic                 pop_valid,
   input  logic                 pop,
   output mbps_pkg::result_type pop_data
);

   localparam logic [mbps_pkg::QUEUE_COUNT_BITS-1:0] FULL_COUNT =
      mbps_pkg::QUEUE_COUNT_BITS'(mbps_pkg::QUEUE_DEPTH);

   mbps_pkg::result_type entries_ff [mbps_pkg::QUEUE_DEPTH];
   logic [mbps_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mbps_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mbps_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == FULL_COUNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

### src/mbps_back.sv
module mbps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop,
   input  mbps_pkg::result_type pop_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [mbps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   logic                 valid_ff, valid_in;
   mbps_pkg::result_type data_ff;
   logic                 load;

   // refill the output register whenever it is empty or being drained
   assign load = pop_valid && (!valid_ff || rsp_tready);
   assign pop  = load;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= pop_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, data_ff.match_offset, data_ff.match_found};
   assign rsp_tlast  = data_ff.end_of_region;

endmodule

### src/masked_byte_pattern_scanner.sv
// masked byte pattern scanner
// req_ channel takes one region byte per transfer; req_tlast marks the final
// byte of a region. rsp_ channel gives a transfer for every match and for the
// final byte of each region: rsp_tdata[0] match found, [32:1] start offset of
// the match (zero when none), rsp_tlast end of region.
// csr_ port writes pattern bytes, care mask, pattern length and first-only
// mode; write only while no region byte is in flight.
// one byte is accepted every cycle while the queue has room; a result goes
// through the queue and then the output register. the window compare, offset
// subtract and region state update are done in the cycle the byte is taken.
// a four-entry queue sits between the scan logic and the output register, so
// req_tready stays high while the receiver stalls until the queue fills;
// bytes that give no result never occupy it.
// reset clears the window, the byte counter, the queue and the output, and
// loads pattern 0, care mask all ones, length 1, first-only off.
module masked_byte_pattern_scanner #(
   parameter int PATTERN_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // match_found, match_offset[31:0], zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   mbps_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 push_valid, push_ready;
   mbps_pkg::result_type push_data;
   logic                 pop_valid, pop;
   mbps_pkg::result_type pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (mbps_pkg::csr_index_type'(csr_index))
            mbps_pkg::CSR_PATTERN: cfg_in.pattern_word   = csr_wdata;
            mbps_pkg::CSR_CARE:    cfg_in.care_mask      = csr_wdata[7:0];
            mbps_pkg::CSR_LENGTH:  cfg_in.pattern_length = csr_wdata[3:0];
            mbps_pkg::CSR_FIRST:   cfg_in.first_only     = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_word   <= 64'd0;
         cfg_ff.care_mask      <= 8'hff;
         cfg_ff.pattern_length <= 4'd1;
         cfg_ff.first_only     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbps_front #(
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   mbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   mbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
